// ----- hdl/imfp_pkg.sv -----
package imfp_pkg;

   localparam int MsgBytes = 128;
   localparam int PosW     = $clog2(MsgBytes + 1);
   localparam int OffW     = 7;
   localparam int NumW     = 32;
   localparam int OffCount = 7;

   // parse phases
   localparam logic [3:0] PhChan  = 4'd0;
   localparam logic [3:0] PhStamp = 4'd1;
   localparam logic [3:0] PhTraf  = 4'd2;
   localparam logic [3:0] PhDial  = 4'd3;
   localparam logic [3:0] PhServ  = 4'd4;
   localparam logic [3:0] PhLine2 = 4'd5;
   localparam logic [3:0] PhFSrc  = 4'd6;
   localparam logic [3:0] PhFUser = 4'd7;
   localparam logic [3:0] PhFP1   = 4'd8;
   localparam logic [3:0] PhFP2   = 4'd9;
   localparam logic [3:0] PhThird = 4'd10;
   localparam logic [3:0] PhDone  = 4'd11;
   localparam logic [3:0] PhBad   = 4'd12;

   // slots of the offset table
   localparam int IxDial = 0;
   localparam int IxServ = 1;
   localparam int IxSrc  = 2;
   localparam int IxUser = 3;
   localparam int IxP1   = 4;
   localparam int IxP2   = 5;
   localparam int IxOrig = 6;

   localparam logic [7:0] ChNul   = 8'h00;
   localparam logic [7:0] ChDot   = 8'h2E;
   localparam logic [7:0] ChNl    = 8'h0A;
   localparam logic [7:0] ChZero  = 8'h30;
   localparam logic [7:0] ChSeven = 8'h37;

   localparam int RspDataW = 152;

   typedef struct packed {
      logic [3:0]                      phase;
      logic [PosW-1:0]                 pos;
      logic [NumW-1:0]                 chan;
      logic [NumW-1:0]                 stamp;
      logic [NumW-1:0]                 traf;
      logic [OffCount-1:0][OffW-1:0]   offs;
      logic                            ovf;
      logic                            bad;
   } parse_state_type;

   typedef struct packed {
      logic            number_overflow;
      logic [OffW-1:0] origin_at;
      logic [OffW-1:0] second_param_at;
      logic [OffW-1:0] first_param_at;
      logic [OffW-1:0] user_at;
      logic [OffW-1:0] source_at;
      logic [OffW-1:0] service_at;
      logic [OffW-1:0] dial_at;
      logic [NumW-1:0] traffic_class;
      logic [NumW-1:0] time_stamp;
      logic [NumW-1:0] channel;
      logic            status;
   } parse_result_type;

endpackage

// ----- hdl/imfp_step.sv -----
module imfp_step (
   input  imfp_pkg::parse_state_type  cur_state,
   input  logic [7:0]                 msg_byte,
   input  logic                       last_byte,
   output imfp_pkg::parse_state_type  state_in,
   output imfp_pkg::parse_result_type result
);

   imfp_pkg::parse_state_type s;
   logic [imfp_pkg::PosW-1:0] p;
   logic [imfp_pkg::PosW-1:0] p_inc;
   logic [imfp_pkg::OffW-1:0] off_here;
   logic [imfp_pkg::OffW-1:0] off_next;
   logic [imfp_pkg::NumW-1:0] acc_sel;
   logic [imfp_pkg::NumW-1:0] acc_new;
   logic                      acc_ovf;
   logic                      is_oct;
   logic                      take;
   logic                      do_fields;
   logic [1:0]                k;
   logic                      final_bad;

   assign p        = cur_state.pos;
   assign p_inc    = p + imfp_pkg::PosW'(1);
   assign off_here = imfp_pkg::OffW'(p);
   assign off_next = imfp_pkg::OffW'(p_inc);
   assign take     = p < imfp_pkg::PosW'(imfp_pkg::MsgBytes);
   assign is_oct   = (msg_byte >= imfp_pkg::ChZero) && (msg_byte <= imfp_pkg::ChSeven);

   // one shift-add unit serves whichever header number is open
   always_comb begin
      case (cur_state.phase)
         imfp_pkg::PhStamp: acc_sel = cur_state.stamp;
         imfp_pkg::PhTraf:  acc_sel = cur_state.traf;
         default:           acc_sel = cur_state.chan;
      endcase
   end

   assign acc_new = {acc_sel[imfp_pkg::NumW-4:0], msg_byte[2:0]};
   assign acc_ovf = acc_sel[imfp_pkg::NumW-1:imfp_pkg::NumW-3] != 3'd0;

   always_comb begin
      s         = cur_state;
      do_fields = 1'b0;
      k         = 2'd0;
      if (take) begin
         s.pos = p_inc;
         case (cur_state.phase)
            imfp_pkg::PhChan, imfp_pkg::PhStamp, imfp_pkg::PhTraf: begin
               if (is_oct) begin
                  if (acc_ovf) begin
                     s.ovf = 1'b1;
                  end
                  case (cur_state.phase)
                     imfp_pkg::PhStamp: s.stamp = acc_new;
                     imfp_pkg::PhTraf:  s.traf  = acc_new;
                     default:           s.chan  = acc_new;
                  endcase
               end else if (msg_byte == imfp_pkg::ChDot &&
                            cur_state.phase != imfp_pkg::PhTraf) begin
                  s.phase = cur_state.phase + 4'd1;
               end else if (msg_byte == imfp_pkg::ChNl) begin
                  s.offs[imfp_pkg::IxDial] = off_next;
                  s.phase = imfp_pkg::PhDial;
               end else begin
                  s.bad   = 1'b1;
                  s.phase = imfp_pkg::PhBad;
               end
            end
            imfp_pkg::PhDial: begin
               if (msg_byte == imfp_pkg::ChNul) begin
                  s.phase = imfp_pkg::PhDone;
               end else if (msg_byte == imfp_pkg::ChNl) begin
                  s.phase = imfp_pkg::PhLine2;
               end else if (msg_byte == imfp_pkg::ChDot) begin
                  s.offs[imfp_pkg::IxServ] = off_next;
                  s.phase = imfp_pkg::PhServ;
               end
            end
            imfp_pkg::PhServ: begin
               if (msg_byte == imfp_pkg::ChNul) begin
                  s.phase = imfp_pkg::PhDone;
               end else if (msg_byte == imfp_pkg::ChNl) begin
                  s.phase = imfp_pkg::PhLine2;
               end
            end
            imfp_pkg::PhLine2: begin
               if (msg_byte == imfp_pkg::ChNul) begin
                  s.phase = imfp_pkg::PhDone;
               end else begin
                  // open the source string here, then treat the byte as a field byte
                  s.offs[imfp_pkg::IxSrc] = off_here;
                  s.phase   = imfp_pkg::PhFSrc;
                  do_fields = 1'b1;
               end
            end
            imfp_pkg::PhFSrc, imfp_pkg::PhFUser, imfp_pkg::PhFP1, imfp_pkg::PhFP2: begin
               do_fields = 1'b1;
            end
            imfp_pkg::PhThird: begin
               if (msg_byte == imfp_pkg::ChDot) begin
                  s.offs[imfp_pkg::IxOrig] = off_next;
                  s.phase = imfp_pkg::PhDone;
               end else if (msg_byte == imfp_pkg::ChNul || msg_byte == imfp_pkg::ChNl) begin
                  s.phase = imfp_pkg::PhDone;
               end
            end
            default: begin
            end
         endcase

         if (do_fields) begin
            k = 2'(s.phase - imfp_pkg::PhFSrc);
            if (msg_byte == imfp_pkg::ChDot) begin
               if (k != 2'd3) begin
                  s.offs[imfp_pkg::IxUser + int'(k)] = off_next;
                  s.phase = s.phase + 4'd1;
               end else begin
                  s.phase = imfp_pkg::PhDone;
               end
            end else if (msg_byte == imfp_pkg::ChNl) begin
               // third line: shift source, uid, param1 down one slot
               s.offs[imfp_pkg::IxP2]   = s.offs[imfp_pkg::IxP1];
               s.offs[imfp_pkg::IxP1]   = s.offs[imfp_pkg::IxUser];
               s.offs[imfp_pkg::IxUser] = s.offs[imfp_pkg::IxSrc];
               s.offs[imfp_pkg::IxSrc]  = off_next;
               s.phase = imfp_pkg::PhThird;
            end else if (msg_byte == imfp_pkg::ChNul) begin
               s.phase = imfp_pkg::PhDone;
            end
         end
      end
   end

   // the terminating NUL only matters while the header is still open
   assign final_bad = s.bad || s.phase == imfp_pkg::PhChan ||
                      s.phase == imfp_pkg::PhStamp || s.phase == imfp_pkg::PhTraf;

   assign state_in = last_byte ? imfp_pkg::parse_state_type'('0) : s;

   always_comb begin
      result = '0;
      result.status = final_bad;
      if (!final_bad) begin
         result.channel         = s.chan;
         result.time_stamp      = s.stamp;
         result.traffic_class   = s.traf;
         result.dial_at         = s.offs[imfp_pkg::IxDial];
         result.service_at      = s.offs[imfp_pkg::IxServ];
         result.source_at       = s.offs[imfp_pkg::IxSrc];
         result.user_at         = s.offs[imfp_pkg::IxUser];
         result.first_param_at  = s.offs[imfp_pkg::IxP1];
         result.second_param_at = s.offs[imfp_pkg::IxP2];
         result.origin_at       = s.offs[imfp_pkg::IxOrig];
         result.number_overflow = s.ovf;
      end
   end

endmodule

// ----- hdl/incall_message_field_parser.sv -----
// Channel   Dir  Payload
// req_      in   tdata[7:0] msg_byte, tlast last_byte
// rsp_      out  tdata result fields (status lowest), one transfer per message
//
// Takes one byte per cycle while the input stage is not stalled. A byte goes into an input register, then one pass of
// parse logic updates the phase, accumulators and offset table.
// On a last byte the parse result is captured in the output register.
// The input stage stalls only when a last byte waits on a full, unaccepted result register.
// Synchronous active-high reset returns the parser to the start of a header.
module incall_message_field_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] msg_byte
   input  logic                          req_tlast,   // last_byte
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [0] status, [32:1] channel, [64:33] time_stamp, [96:65] traffic_class,
   // [103:97] dial_at, [110:104] service_at, [117:111] source_at,
   // [124:118] user_at, [131:125] first_param_at, [138:132] second_param_at,
   // [145:139] origin_at, [146] number_overflow, [151:147] zero
   output logic [imfp_pkg::RspDataW-1:0] rsp_tdata
);

   logic                       in_valid_ff, in_valid_in;
   logic [7:0]                 in_byte_ff;
   logic                       in_last_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   imfp_pkg::parse_result_type rsp_data_ff;
   imfp_pkg::parse_state_type  state_ff;
   imfp_pkg::parse_state_type  state_in;
   imfp_pkg::parse_result_type result;
   logic                       advance;
   logic                       req_xfer;

   imfp_step u_step (
      .cur_state (state_ff),
      .msg_byte  (in_byte_ff),
      .last_byte (in_last_ff),
      .state_in  (state_in),
      .result    (result)
   );

   // a plain byte always moves on; a last byte needs room in the result register
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (advance && in_last_ff) ? 1'b1 :
                         (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = imfp_pkg::RspDataW'(rsp_data_ff);

`ifndef ASSERT_OFF
   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> state_ff == '0)
      else $error("parser state not cleared after last byte");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.pos <= imfp_pkg::PosW'(imfp_pkg::MsgBytes))
      else $error("byte position past buffer size");

   a_bad_clears_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status |->
         rsp_data_ff.channel == '0 && rsp_data_ff.dial_at == '0 &&
         rsp_data_ff.number_overflow == 1'b0)
      else $error("bad header result carries field data");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !(advance && in_last_ff))
      else $error("result register overwritten while stalled");
`endif

endmodule

// ----- dv/tb_top.sv -----
module tb_top;

   typedef struct {
      logic [7:0] data;
      logic       last;
      bit         hold;   // wait for all pending results before this byte goes out
   } msg_beat_type;

   logic                          clock;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [7:0]                    req_tdata  = 8'h00;   // [7:0] msg_byte
   logic                          req_tlast  = 1'b0;    // last_byte
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [imfp_pkg::RspDataW-1:0] rsp_tdata;  // status lowest, see the block's port list

   incall_message_field_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // stimulus and expectations
   msg_beat_type               beat_q[$];
   logic [7:0]                 msg[$];
   imfp_pkg::parse_result_type expected_fields[$];
   msg_beat_type               cur_beat;
   int                         bytes_total    = 0;
   int                         bytes_accepted = 0;
   int                         msgs_built     = 0;
   int                         errors         = 0;
   int                         results_seen   = 0;
   int                         bad_headers    = 0;
   int                         overflows      = 0;
   int                         hold_points    = 0;
   int                         send_wait      = 0;
   int                         recv_wait      = 0;
   bit                         tx_calm        = 1'b0;
   bit                         rx_calm        = 1'b0;

   // parser image
   logic [3:0]                 ph;
   int unsigned                at;
   logic [imfp_pkg::NumW-1:0]  chan_acc, stamp_acc, traf_acc;
   logic [imfp_pkg::OffW-1:0]  offs [imfp_pkg::OffCount];
   logic                       ovf, bad;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int draw_wait(inout bit calm);
      if ($urandom_range(0, 29) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, 18);
   endfunction

   // ---------------------------------------------------------------- prediction

   task automatic clear_parser();
      ph = imfp_pkg::PhChan;
      at = 0;
      chan_acc = '0;
      stamp_acc = '0;
      traf_acc = '0;
      foreach (offs[i]) offs[i] = '0;
      ovf = 1'b0;
      bad = 1'b0;
   endtask

   task automatic header_char(inout logic [imfp_pkg::NumW-1:0] acc, input logic [7:0] c,
                              input int unsigned p, input bit dot_ok);
      if (c >= imfp_pkg::ChZero && c <= imfp_pkg::ChSeven) begin
         if (acc[imfp_pkg::NumW-1:imfp_pkg::NumW-3] != 3'b000) ovf = 1'b1;
         acc = {acc[imfp_pkg::NumW-4:0], c[2:0]};
      end else if (c == imfp_pkg::ChDot && dot_ok) begin
         ph = ph + 4'd1;
      end else if (c == imfp_pkg::ChNl) begin
         offs[imfp_pkg::IxDial] = imfp_pkg::OffW'(p + 1);
         ph = imfp_pkg::PhDial;
      end else begin
         bad = 1'b1;
         ph = imfp_pkg::PhBad;
      end
   endtask

   task automatic field_char(input logic [7:0] c, input int unsigned p);
      int unsigned k;
      k = ph - imfp_pkg::PhFSrc;
      if (c == imfp_pkg::ChDot) begin
         if (k < 3) begin
            offs[imfp_pkg::IxUser + k] = imfp_pkg::OffW'(p + 1);
            ph = ph + 4'd1;
         end else begin
            ph = imfp_pkg::PhDone;
         end
      end else if (c == imfp_pkg::ChNl) begin
         // third line: push the second-line fields down one slot
         offs[imfp_pkg::IxP2]   = offs[imfp_pkg::IxP1];
         offs[imfp_pkg::IxP1]   = offs[imfp_pkg::IxUser];
         offs[imfp_pkg::IxUser] = offs[imfp_pkg::IxSrc];
         offs[imfp_pkg::IxSrc]  = imfp_pkg::OffW'(p + 1);
         ph = imfp_pkg::PhThird;
      end else if (c == imfp_pkg::ChNul) begin
         ph = imfp_pkg::PhDone;
      end
   endtask

   task automatic parse_char(input logic [7:0] c, input int unsigned p);
      case (ph)
         imfp_pkg::PhChan:  header_char(chan_acc, c, p, 1'b1);
         imfp_pkg::PhStamp: header_char(stamp_acc, c, p, 1'b1);
         imfp_pkg::PhTraf:  header_char(traf_acc, c, p, 1'b0);
         imfp_pkg::PhDial: begin
            if (c == imfp_pkg::ChNul) ph = imfp_pkg::PhDone;
            else if (c == imfp_pkg::ChNl) ph = imfp_pkg::PhLine2;
            else if (c == imfp_pkg::ChDot) begin
               offs[imfp_pkg::IxServ] = imfp_pkg::OffW'(p + 1);
               ph = imfp_pkg::PhServ;
            end
         end
         imfp_pkg::PhServ: begin
            if (c == imfp_pkg::ChNul) ph = imfp_pkg::PhDone;
            else if (c == imfp_pkg::ChNl) ph = imfp_pkg::PhLine2;
         end
         imfp_pkg::PhLine2: begin
            if (c == imfp_pkg::ChNul) begin
               ph = imfp_pkg::PhDone;
            end else begin
               offs[imfp_pkg::IxSrc] = imfp_pkg::OffW'(p);
               ph = imfp_pkg::PhFSrc;
               field_char(c, p);
            end
         end
         imfp_pkg::PhThird: begin
            if (c == imfp_pkg::ChDot) begin
               offs[imfp_pkg::IxOrig] = imfp_pkg::OffW'(p + 1);
               ph = imfp_pkg::PhDone;
            end else if (c == imfp_pkg::ChNul || c == imfp_pkg::ChNl) begin
               ph = imfp_pkg::PhDone;
            end
         end
         default: begin
            if (ph >= imfp_pkg::PhFSrc && ph <= imfp_pkg::PhFP2) field_char(c, p);
         end
      endcase
   endtask

   task automatic predict_byte(input logic [7:0] c, input logic last);
      imfp_pkg::parse_result_type r;
      r = '0;
      if (at < imfp_pkg::MsgBytes) begin
         parse_char(c, at);
         at++;
      end
      if (last) begin
         // the message end reads as a NUL just past the stored bytes
         parse_char(imfp_pkg::ChNul, at);
         if (bad) begin
            r.status = 1'b1;
         end else begin
            r.channel         = chan_acc;
            r.time_stamp      = stamp_acc;
            r.traffic_class   = traf_acc;
            r.dial_at         = offs[imfp_pkg::IxDial];
            r.service_at      = offs[imfp_pkg::IxServ];
            r.source_at       = offs[imfp_pkg::IxSrc];
            r.user_at         = offs[imfp_pkg::IxUser];
            r.first_param_at  = offs[imfp_pkg::IxP1];
            r.second_param_at = offs[imfp_pkg::IxP2];
            r.origin_at       = offs[imfp_pkg::IxOrig];
            r.number_overflow = ovf;
         end
         expected_fields.push_back(r);
         clear_parser();
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic check_result(input logic [imfp_pkg::RspDataW-1:0] word);
      imfp_pkg::parse_result_type got, want;
      got = word[$bits(imfp_pkg::parse_result_type)-1:0];
      if (expected_fields.size() == 0) begin
         $display("%0t: unexpected result, expected none actual %h", $time, word);
         errors++;
      end else begin
         want = expected_fields.pop_front();
         results_seen++;
         if (want.status) bad_headers++;
         if (want.number_overflow) overflows++;
         compare_field("status", want.status, got.status);
         compare_field("channel", want.channel, got.channel);
         compare_field("time_stamp", want.time_stamp, got.time_stamp);
         compare_field("traffic_class", want.traffic_class, got.traffic_class);
         compare_field("dial_at", want.dial_at, got.dial_at);
         compare_field("service_at", want.service_at, got.service_at);
         compare_field("source_at", want.source_at, got.source_at);
         compare_field("user_at", want.user_at, got.user_at);
         compare_field("first_param_at", want.first_param_at, got.first_param_at);
         compare_field("second_param_at", want.second_param_at, got.second_param_at);
         compare_field("origin_at", want.origin_at, got.origin_at);
         compare_field("number_overflow", want.number_overflow, got.number_overflow);
         compare_field("pad bits", '0,
                       word[imfp_pkg::RspDataW-1:$bits(imfp_pkg::parse_result_type)]);
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   task automatic put_char(input logic [7:0] c);
      msg.push_back(c);
   endtask

   task automatic put_str(input string s);
      for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
   endtask

   task automatic put_text(input int n);
      logic [7:0] c;
      repeat (n) begin
         do c = 8'($urandom_range(1, 255));
         while (c == imfp_pkg::ChNl || c == imfp_pkg::ChDot);
         msg.push_back(c);
      end
   endtask

   task automatic put_digits(input int n);
      repeat (n) msg.push_back(8'(imfp_pkg::ChZero + $urandom_range(0, 7)));
   endtask

   task automatic finish_message(input bit hold);
      msg_beat_type b;
      if (msg.size() == 0) put_char(imfp_pkg::ChNl);
      foreach (msg[i]) begin
         b.data = msg[i];
         b.last = (i == msg.size() - 1);
         b.hold = hold && (i == 0);
         beat_q.push_back(b);
      end
      if (hold) hold_points++;
      bytes_total += msg.size();
      msgs_built++;
      msg.delete();
   endtask

   // mostly well-formed call request; pad_to stretches the dial string
   task automatic compose_call(input int pad_to);
      int r;
      r = $urandom_range(0, 9);
      put_digits(r == 0 ? $urandom_range(10, 14) : $urandom_range(0, 4));
      if ($urandom_range(0, 1)) begin
         put_char(imfp_pkg::ChDot);
         put_digits($urandom_range(0, 4));
         if ($urandom_range(0, 1)) begin
            put_char(imfp_pkg::ChDot);
            put_digits($urandom_range(0, 12));
         end
      end
      r = $urandom_range(0, 11);
      if (r == 0) put_char(8'($urandom_range(0, 255)));
      else if (r == 1) put_char(imfp_pkg::ChDot);
      if (r != 2) put_char(imfp_pkg::ChNl);
      put_text($urandom_range(0, 5));
      if (pad_to > msg.size()) put_text(pad_to - msg.size());
      if ($urandom_range(0, 1)) begin
         put_char(imfp_pkg::ChDot);
         put_text($urandom_range(0, 4));
      end
      if ($urandom_range(0, 3) != 0) begin
         put_char(imfp_pkg::ChNl);
         put_text($urandom_range(0, 4));
         repeat ($urandom_range(0, 4)) begin
            put_char(imfp_pkg::ChDot);
            put_text($urandom_range(0, 3));
         end
         if ($urandom_range(0, 1)) begin
            put_char(imfp_pkg::ChNl);
            put_text($urandom_range(0, 4));
            if ($urandom_range(0, 1)) begin
               put_char(imfp_pkg::ChDot);
               put_text($urandom_range(0, 3));
            end
            if ($urandom_range(0, 2) == 0) put_char(imfp_pkg::ChNl);
         end
      end
      // embedded NUL followed by junk that must be ignored
      if ($urandom_range(0, 7) == 0) begin
         put_char(imfp_pkg::ChNul);
         repeat ($urandom_range(0, 4)) put_char(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic compose_noise();
      int r;
      repeat ($urandom_range(1, 8)) begin
         r = $urandom_range(0, 9);
         if (r < 4) put_digits(1);
         else if (r == 4) put_char(imfp_pkg::ChDot);
         else if (r == 5) put_char(imfp_pkg::ChNl);
         else if (r == 6) put_char(imfp_pkg::ChNul);
         else put_char(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int random_bytes;
      int first_random;

      clear_parser();

      // directed messages
      put_str("\n");               finish_message(1'b0);
      put_str("...");              finish_message(1'b0);
      put_str("5");                finish_message(1'b0);
      put_char(imfp_pkg::ChNul);   finish_message(1'b0);
      put_char(8'hFF);             finish_message(1'b0);
      put_str("77777777777.0\n");  finish_message(1'b0);
      put_str("1.2.3\n");          finish_message(1'b0);

      // random part, first message waits for the directed results to drain
      first_random = bytes_total;
      random_bytes = 0;
      while (random_bytes < 520 || msgs_built < 21) begin
         if (msgs_built == 12) begin
            // service dot on the last stored byte: offset wraps to absent
            put_char(imfp_pkg::ChNl);
            put_text(imfp_pkg::MsgBytes - 2);
            put_char(imfp_pkg::ChDot);
         end else if (msgs_built == 20) begin
            // run past the buffer; the tail is ignored
            compose_call(imfp_pkg::MsgBytes - 3);
            put_char(imfp_pkg::ChDot);
            put_text(12);
         end else if ($urandom_range(0, 29) == 0) begin
            compose_call($urandom_range(100, 140));
         end else if ($urandom_range(0, 3) == 0) begin
            compose_noise();
         end else begin
            compose_call(0);
         end
         finish_message(msgs_built == 7 || $urandom_range(0, 9) == 0);
         random_bytes = bytes_total - first_random;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (bytes_accepted < bytes_total) @(posedge clock);
      while (expected_fields.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d messages in %0d bytes, %0d drain pauses",
               msgs_built, bytes_total, hold_points);
      $display("results checked %0d: %0d bad headers, %0d with number overflow",
               results_seen, bad_headers, overflows);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait = draw_wait(tx_calm);
      end else begin
         if (req_tvalid && req_tready) begin
            predict_byte(cur_beat.data, cur_beat.last);
            bytes_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_tvalid <= 1'b0;
            end else if (beat_q.size() != 0 &&
                         !(beat_q[0].hold && expected_fields.size() != 0)) begin
               cur_beat = beat_q.pop_front();
               req_tdata  <= cur_beat.data;
               req_tlast  <= cur_beat.last;
               req_tvalid <= 1'b1;
               send_wait = draw_wait(tx_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result(rsp_tdata);
            recv_wait = draw_wait(rx_calm);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

endmodule
